FILE: rtl/core/bfe_pkg.sv
// ============================================================================
// bfe_pkg: shared types and constants of the binary frame extractor
// Request and result payload structs, framing byte values, status codes and
// the command and status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package bfe_pkg;

    // Default size of the receive byte buffer.
    localparam int BFE_BUFFER_DEPTH = 4096;

    // Framing characters.
    localparam logic [7:0] SYNC_CHAR = 8'h24;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_I    = 8'h49;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    // Frame geometry in bytes.
    localparam int HEADER_BYTES    = 8;
    localparam int EPILOGUE_OFFSET = 10;
    localparam int FRAMING_BYTES   = 12;
    localparam int CHECKSUM_BYTES  = 2;
    localparam int RESYNC_SKIP     = 4;

    // Width of the remaining payload byte count (length plus checksum).
    localparam int DRAIN_W = 17;
    localparam int LEN_W   = 16;

    // Request types.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_GIVEN  = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    // Header byte positions after the sync character.
    localparam logic [2:0] HB_B     = 3'd1;
    localparam logic [2:0] HB_I     = 3'd2;
    localparam logic [2:0] HB_N     = 3'd3;
    localparam logic [2:0] HB_BLOCK = 3'd4;
    localparam logic [2:0] HB_ZERO  = 3'd5;
    localparam logic [2:0] HB_LEN_L = 3'd6;
    localparam logic [2:0] HB_LEN_H = 3'd7;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] block_id;
        logic [7:0] payload_byte;
        logic       frame_last;
    } out_t;

    // Which logical index drives the buffer address.
    typedef enum logic [1:0] {
        A_POS  = 2'd0,
        A_EPI  = 2'd1,
        A_SCAN = 2'd2,
        A_FILL = 2'd3
    } addr_sel_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic      accept;
        addr_sel_t addr_sel;
        logic      pos_inc;
        logic      pos_add4;
        logic      hdr_start;
        logic      k_inc;
        logic      epi_start;
        logic      hdr_chk;
        logic      epi_chk;
        logic      start_drain;
        logic      give;
        logic      discard_pos;
        logic      empty;
        logic      emit;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic req_pull;
        logic drain_nz;
        logic pos_ge_fill;
        logic is_sync;
        logic hdr_short;
        logic k_is_last;
        logic k_is_zero;
        logic hdr_bad;
        logic frame_short;
        logic epi_bad;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfe_ram.sv
// ============================================================================
// bfe_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bfe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/bfe_ctrl.sv
// ============================================================================
// bfe_ctrl: request sequencer of the binary frame extractor
// Walks a pull through sync search, header check, length check, epilogue
// check and byte hand-out, and schedules the result of each request into the output stage.
// ============================================================================
`default_nettype none

module bfe_ctrl
    import bfe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SCAN_RD = 11'b000_0000_0010,
        S_SCAN_CK = 11'b000_0000_0100,
        S_HDR_RD  = 11'b000_0000_1000,
        S_HDR_CK  = 11'b000_0001_0000,
        S_LEN_CK  = 11'b000_0010_0000,
        S_EPI_RD  = 11'b000_0100_0000,
        S_EPI_CK  = 11'b000_1000_0000,
        S_GIVE_RD = 11'b001_0000_0000,
        S_GIVE_CK = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.addr_sel = A_FILL;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!sts.req_pull) begin
                        state_next = S_EMIT;
                    end else if (sts.drain_nz) begin
                        state_next = S_GIVE_RD;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                cmd.addr_sel = A_POS;
                if (sts.pos_ge_fill) begin
                    cmd.empty  = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if (!sts.is_sync) begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end else if (sts.hdr_short) begin
                    cmd.discard_pos = 1'b1;
                    state_next      = S_EMIT;
                end else begin
                    cmd.hdr_start = 1'b1;
                    state_next    = S_HDR_RD;
                end
            end
            S_HDR_RD: begin
                cmd.addr_sel = A_POS;
                state_next   = S_HDR_CK;
            end
            S_HDR_CK: begin
                cmd.hdr_chk = 1'b1;
                if (sts.k_is_last) begin
                    state_next = S_LEN_CK;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_HDR_RD;
                end
            end
            S_LEN_CK: begin
                if (sts.hdr_bad) begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end else if (sts.frame_short) begin
                    cmd.discard_pos = 1'b1;
                    state_next      = S_EMIT;
                end else begin
                    cmd.epi_start = 1'b1;
                    state_next    = S_EPI_RD;
                end
            end
            S_EPI_RD: begin
                cmd.addr_sel = A_EPI;
                state_next   = S_EPI_CK;
            end
            S_EPI_CK: begin
                cmd.epi_chk = 1'b1;
                if (sts.k_is_zero) begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_EPI_RD;
                end else if (sts.epi_bad) begin
                    cmd.pos_add4 = 1'b1;
                    state_next   = S_SCAN_RD;
                end else begin
                    cmd.start_drain = 1'b1;
                    state_next      = S_GIVE_RD;
                end
            end
            S_GIVE_RD: begin
                cmd.addr_sel = A_SCAN;
                state_next   = S_GIVE_CK;
            end
            S_GIVE_CK: begin
                cmd.give   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bfe_dp.sv
// ============================================================================
// bfe_dp: datapath of the binary frame extractor
// Circular buffer pointers, scan cursor, header and epilogue checks, drain
// counters, result register and output stage.
// ============================================================================
`default_nettype none

module bfe_dp
    import bfe_pkg::*;
#(
    parameter int BUFFER_DEPTH = BFE_BUFFER_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire in_t                             s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output out_t                                 m_data,
    input  wire cmd_t                            cmd,
    output sts_t                                 sts,
    output logic                                 ram_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      ram_addr,
    output logic [7:0]                           ram_wdata,
    input  wire logic [7:0]                      ram_rdata
);

    // Index width, count width (holds the depth itself) and a wide width
    // for comparing against the frame length.
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int EW = ((LW > DRAIN_W) ? LW : DRAIN_W) + 1;
    localparam logic [LW:0] DEPTH_X = (LW + 1)'(BUFFER_DEPTH);

    logic [LW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [LW-1:0]      scan_reg, scan_next;
    logic [LW-1:0]      pos_reg, pos_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic [7:0]         block_reg, block_next;
    logic [7:0]         cand_blk_reg, cand_blk_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LW-1:0]      epi_base_reg, epi_base_next;
    logic [2:0]         k_reg, k_next;
    logic               hdr_bad_reg, hdr_bad_next;
    logic               epi_bad_reg, epi_bad_next;
    out_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic [LW-1:0] idx;
    logic [LW:0]   phys_sum;
    logic [LW-1:0] disc_n;
    logic [LW:0]   head_sum;
    logic [AW-1:0] head_wrap;
    logic [LW-1:0] avail;
    logic          buf_full;
    logic          epi_bad_now;
    logic          out_free;

    // Logical index to physical buffer address, wrapped around the depth.
    always_comb begin
        unique case (cmd.addr_sel)
            A_POS:   idx = pos_reg + LW'(k_reg);
            A_EPI:   idx = epi_base_reg + LW'(k_reg);
            A_SCAN:  idx = scan_reg;
            A_FILL:  idx = fill_reg;
            default: idx = fill_reg;
        endcase
        phys_sum = (LW + 1)'(head_reg) + (LW + 1)'(idx);
        if (phys_sum >= DEPTH_X) begin
            ram_addr = AW'(phys_sum - DEPTH_X);
        end else begin
            ram_addr = AW'(phys_sum);
        end
    end

    // Discarding bytes from the front advances the head pointer.
    always_comb begin
        if (cmd.give) begin
            disc_n = scan_reg + LW'(3);
        end else begin
            disc_n = pos_reg;
        end
        head_sum = (LW + 1)'(head_reg) + (LW + 1)'(disc_n);
        if (head_sum >= DEPTH_X) begin
            head_wrap = AW'(head_sum - DEPTH_X);
        end else begin
            head_wrap = AW'(head_sum);
        end
    end

    assign buf_full  = (fill_reg == LW'(BUFFER_DEPTH));
    assign avail     = fill_reg - pos_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign ram_wdata = s_data.rx_byte;
    assign ram_we    = cmd.accept && (s_data.req_type == REQ_PUSH) && !buf_full;

    // Epilogue check folds the current byte into the running flag.
    always_comb begin
        if (k_reg == 3'd0) begin
            epi_bad_now = epi_bad_reg | (ram_rdata != CHAR_CR);
        end else begin
            epi_bad_now = epi_bad_reg | (ram_rdata != CHAR_LF);
        end
    end

    // Status toward the controller.
    always_comb begin
        sts.req_pull    = (s_data.req_type == REQ_PULL);
        sts.drain_nz    = (drain_reg != '0);
        sts.pos_ge_fill = (pos_reg >= fill_reg);
        sts.is_sync     = (ram_rdata == SYNC_CHAR);
        sts.hdr_short   = (avail < LW'(HEADER_BYTES));
        sts.k_is_last   = (k_reg == HB_LEN_H);
        sts.k_is_zero   = (k_reg == 3'd0);
        sts.hdr_bad     = hdr_bad_reg;
        sts.frame_short = (EW'(avail) < (EW'(len_reg) + EW'(FRAMING_BYTES)));
        sts.epi_bad     = epi_bad_now;
        sts.out_free    = out_free;
    end

    // Next-state logic of the datapath registers.
    always_comb begin
        fill_next     = fill_reg;
        head_next     = head_reg;
        scan_next     = scan_reg;
        pos_next      = pos_reg;
        drain_next    = drain_reg;
        block_next    = block_reg;
        cand_blk_next = cand_blk_reg;
        len_next      = len_reg;
        epi_base_next = epi_base_reg;
        k_next        = k_reg;
        hdr_bad_next  = hdr_bad_reg;
        epi_bad_next  = epi_bad_reg;
        res_next      = res_reg;

        // Request accepted: a push stores the byte, a pull starts at the cursor.
        if (cmd.accept) begin
            res_next = '0;
            k_next   = 3'd0;
            if (s_data.req_type == REQ_PUSH) begin
                if (buf_full) begin
                    res_next.status = ST_FULL;
                end else begin
                    res_next.status = ST_PUSHED;
                    fill_next       = fill_reg + LW'(1);
                end
            end else begin
                res_next.status = ST_NONE;
                pos_next        = scan_reg;
            end
        end

        // Cursor moves during the search.
        if (cmd.pos_inc) begin
            pos_next = pos_reg + LW'(1);
            k_next   = 3'd0;
        end
        if (cmd.pos_add4) begin
            pos_next = pos_reg + LW'(RESYNC_SKIP);
            k_next   = 3'd0;
        end

        // Header walk over the bytes after the sync character.
        if (cmd.hdr_start) begin
            k_next       = HB_B;
            hdr_bad_next = 1'b0;
        end
        if (cmd.k_inc) begin
            k_next = k_reg + 3'd1;
        end
        if (cmd.hdr_chk) begin
            unique case (k_reg)
                HB_B:     hdr_bad_next = hdr_bad_reg | (ram_rdata != CHAR_B);
                HB_I:     hdr_bad_next = hdr_bad_reg | (ram_rdata != CHAR_I);
                HB_N:     hdr_bad_next = hdr_bad_reg | (ram_rdata != CHAR_N);
                HB_BLOCK: cand_blk_next = ram_rdata;
                HB_ZERO:  hdr_bad_next = hdr_bad_reg | (ram_rdata != 8'h00);
                HB_LEN_L: len_next[7:0] = ram_rdata;
                HB_LEN_H: len_next[15:8] = ram_rdata;
                default:  hdr_bad_next = hdr_bad_reg;
            endcase
        end

        // Epilogue walk over CR and LF.
        if (cmd.epi_start) begin
            k_next        = 3'd0;
            epi_bad_next  = 1'b0;
            epi_base_next = LW'(EW'(pos_reg) + EW'(len_reg) + EW'(EPILOGUE_OFFSET));
        end
        if (cmd.epi_chk) begin
            epi_bad_next = epi_bad_now;
        end

        // Frame validated: set up the drain.
        if (cmd.start_drain) begin
            block_next = cand_blk_reg;
            drain_next = DRAIN_W'(len_reg) + DRAIN_W'(CHECKSUM_BYTES);
            scan_next  = pos_reg + LW'(HEADER_BYTES);
        end

        // One payload byte handed out; the last one drops the whole frame.
        if (cmd.give) begin
            res_next.status       = ST_GIVEN;
            res_next.block_id     = block_reg;
            res_next.payload_byte = ram_rdata;
            res_next.frame_last   = (drain_reg == DRAIN_W'(1));
            drain_next            = drain_reg - DRAIN_W'(1);
            if (drain_reg == DRAIN_W'(1)) begin
                head_next = head_wrap;
                fill_next = fill_reg - disc_n;
                scan_next = '0;
            end else begin
                scan_next = scan_reg + LW'(1);
            end
        end

        // Bytes before an incomplete frame are dropped.
        if (cmd.discard_pos) begin
            head_next = head_wrap;
            fill_next = fill_reg - disc_n;
            scan_next = '0;
        end

        // No sync character left: empty the buffer.
        if (cmd.empty) begin
            fill_next = '0;
            scan_next = '0;
        end
    end

    // Output stage.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            head_reg    <= '0;
            scan_reg    <= '0;
            drain_reg   <= '0;
            block_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            scan_reg    <= scan_next;
            drain_reg   <= drain_next;
            block_reg   <= block_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        cand_blk_reg <= cand_blk_next;
        len_reg      <= len_next;
        epi_base_reg <= epi_base_next;
        k_reg        <= k_next;
        hdr_bad_reg  <= hdr_bad_next;
        epi_bad_reg  <= epi_bad_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    // The buffer never holds more than its depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LW'(BUFFER_DEPTH))
        else $error("fill level exceeds buffer depth");

    // While a frame drains, its next byte lies inside the buffer.
    a_drain_in_buf: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_reg != '0) |-> (scan_reg < fill_reg))
        else $error("drain cursor outside buffered bytes");

    // A byte is handed out only while a frame is draining.
    a_give_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.give |-> (drain_reg != '0))
        else $error("payload byte given with no frame draining");

    // A result is loaded only into a free output stage.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending output");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/binary_frame_extractor_core.sv
// ============================================================================
// binary_frame_extractor_core: binary GPS frame extractor
// Buffers received serial bytes and hands out validated frames one payload
// byte per pull request, tagged with the block id and end-of-frame mark.
//
//   channel  dir  payload               meaning
//   s_*      in   req_type, rx_byte     push a byte or pull a payload byte
//   m_*      out  status, block_id,     one result per request
//                 payload_byte, frame_last
//
// A pull that searches reads the single read port of the byte buffer once per
// byte skipped before a '$', once per header byte checked and once per
// epilogue byte checked, and each read is followed by a check state.
// One request is in work at a time; the next is accepted while the last
// result still waits in the output register.
// Reset is synchronous, active low; the buffer contents need no clearing.
// ============================================================================
`default_nettype none

module binary_frame_extractor_core
    import bfe_pkg::*;
#(
    parameter int BUFFER_DEPTH = BFE_BUFFER_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    cmd_t          cmd;
    sts_t          sts;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // Request sequencer.
    bfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Pointers, checks and output stage.
    bfe_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    // Receive byte buffer.
    bfe_ram #(
        .DATA_W (8),
        .DEPTH  (BUFFER_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ============================================================================
// tb_top: testbench of the binary frame extractor core
// Drives push and pull requests through the valid/ready request channel and
// checks every result against its typed-in value or a cycle-free deframer
// model kept in the bench. A short table of directed requests comes first,
// then framed traffic with random content, broken frames and noise, one frame
// that fills the store exactly and a closing frame too long for the store.
// ============================================================================

module tb_top;
    import bfe_pkg::*;

    localparam int unsigned RUN_LIMIT    = 16_000_000;
    localparam int unsigned RANDOM_ITEMS = 1700;

    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_EPILOGUE
    } flaw_t;

    // One directed request with its result, typed in where it is obvious.
    typedef struct packed {
        logic       req;
        logic [7:0] data_in;
        logic       typed;
        out_t       want;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Deframer model state.
    logic [7:0]  store_mirror [0:BFE_BUFFER_DEPTH-1];
    int unsigned mir_fill  = 0;
    int unsigned mir_scan  = 0;
    int unsigned mir_drain = 0;
    logic [7:0]  mir_block = 8'h00;

    out_t        awaited_results [$];
    int unsigned faults      = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;

    binary_frame_extractor_core #(
        .BUFFER_DEPTH(BFE_BUFFER_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Clock with a period of 4.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer model
    // ------------------------------------------------------------------

    // Bytes at or beyond the fill level read as zero.
    function automatic logic [7:0] mirror_at(int unsigned idx);
        if (idx < mir_fill && idx < BFE_BUFFER_DEPTH) begin
            return store_mirror[idx];
        end
        return 8'h00;
    endfunction

    // Drop the first n bytes and move the rest to the front.
    function automatic void mirror_drop(int unsigned n);
        int unsigned k;
        if (n > mir_fill) begin
            n = mir_fill;
        end
        if (n > 0) begin
            for (k = 0; k + n < mir_fill; k++) begin
                store_mirror[k] = store_mirror[k + n];
            end
        end
        mir_fill -= n;
        mir_scan = 0;
    endfunction

    // Hand out the next payload byte of the frame being drained.
    function automatic out_t mirror_give();
        out_t r;
        r.status       = ST_GIVEN;
        r.block_id     = mir_block;
        r.payload_byte = mirror_at(mir_scan);
        mir_scan++;
        mir_drain--;
        r.frame_last = (mir_drain == 0);
        if (mir_drain == 0) begin
            mirror_drop(mir_scan + CHECKSUM_BYTES);
        end
        return r;
    endfunction

    // Result of one request, updating the model state.
    function automatic out_t deframer_step(in_t req);
        out_t        r;
        int unsigned pos;
        int unsigned flen;
        r = '0;
        r.status = ST_NONE;
        if (req.req_type == REQ_PUSH) begin
            if (mir_fill < BFE_BUFFER_DEPTH) begin
                store_mirror[mir_fill] = req.rx_byte;
                mir_fill++;
                r.status = ST_PUSHED;
            end else begin
                r.status = ST_FULL;
            end
            return r;
        end
        if (mir_drain > 0) begin
            return mirror_give();
        end
        pos = mir_scan;
        while (1'b1) begin
            while (pos < mir_fill && mirror_at(pos) != SYNC_CHAR) begin
                pos++;
            end
            // No sync byte left: the store is emptied.
            if (pos >= mir_fill) begin
                mir_fill = 0;
                mir_scan = 0;
                return r;
            end
            // Header not complete yet.
            if (mir_fill - pos < HEADER_BYTES) begin
                mirror_drop(pos);
                return r;
            end
            if (mirror_at(pos + HB_B) != CHAR_B || mirror_at(pos + HB_I) != CHAR_I ||
                mirror_at(pos + HB_N) != CHAR_N || mirror_at(pos + HB_ZERO) != 8'h00) begin
                pos++;
                continue;
            end
            flen = {mirror_at(pos + HB_LEN_H), mirror_at(pos + HB_LEN_L)};
            // Frame not complete yet.
            if (mir_fill - pos < flen + FRAMING_BYTES) begin
                mirror_drop(pos);
                return r;
            end
            if (mirror_at(pos + flen + EPILOGUE_OFFSET) != CHAR_CR ||
                mirror_at(pos + flen + EPILOGUE_OFFSET + 1) != CHAR_LF) begin
                pos += RESYNC_SKIP;
                continue;
            end
            mir_block = mirror_at(pos + HB_BLOCK);
            mir_drain = flen + CHECKSUM_BYTES;
            mir_scan  = pos + HEADER_BYTES;
            return mirror_give();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request; called and returning at a falling edge. The sender
    // runs in bursts, mostly with idle gaps between them.
    task automatic issue(in_t req, logic typed, out_t want);
        out_t predicted;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        predicted = deframer_step(req);
        awaited_results.push_back(typed ? want : predicted);
        items_sent++;
        s_valid <= 1'b1;
        s_data  <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic pull_once();
        issue('{req_type: REQ_PULL, rx_byte: 8'($urandom_range(0, 255))}, 1'b0, '0);
    endtask

    // Push one byte, sometimes with a pull request ahead of it.
    task automatic push_mixed(logic [7:0] value);
        if ($urandom_range(0, 5) == 0) begin
            pull_once();
        end
        issue('{req_type: REQ_PUSH, rx_byte: value}, 1'b0, '0);
    endtask

    // Hold the sender until every result has come back; s_valid stays low
    // until then.
    task automatic quiesce();
        s_valid <= 1'b0;
        burst_left = 0;
        do begin
            @(negedge aclk);
        end while (awaited_results.size() != 0);
    endtask

    // Push one frame, possibly broken, then pull it out.
    task automatic send_frame(int unsigned flen, flaw_t flaw);
        logic [7:0]  frame_q [$];
        int unsigned k;
        int unsigned spot;
        frame_q = {SYNC_CHAR, CHAR_B, CHAR_I, CHAR_N, 8'($urandom_range(0, 255)), 8'h00,
                   flen[7:0], flen[15:8]};
        for (k = 0; k < flen + CHECKSUM_BYTES; k++) begin
            frame_q.push_back(8'($urandom_range(0, 255)));
        end
        frame_q.push_back(CHAR_CR);
        frame_q.push_back(CHAR_LF);
        if (flaw == FLAW_HEADER) begin
            case ($urandom_range(0, 3))
                0: spot = HB_B;
                1: spot = HB_I;
                2: spot = HB_N;
                default: spot = HB_ZERO;
            endcase
            frame_q[spot] = frame_q[spot] ^ 8'($urandom_range(1, 255));
        end else if (flaw == FLAW_EPILOGUE) begin
            spot = flen + EPILOGUE_OFFSET;
            case ($urandom_range(0, 2))
                0: frame_q[spot] = frame_q[spot] ^ 8'($urandom_range(1, 255));
                1: frame_q[spot + 1] = frame_q[spot + 1] ^ 8'($urandom_range(1, 255));
                default: begin
                    frame_q[spot]     = frame_q[spot] ^ 8'($urandom_range(1, 255));
                    frame_q[spot + 1] = frame_q[spot + 1] ^ 8'($urandom_range(1, 255));
                end
            endcase
        end
        foreach (frame_q[i]) begin
            push_mixed(frame_q[i]);
        end
        k = (flaw == FLAW_NONE) ? flen + CHECKSUM_BYTES + $urandom_range(0, 3)
                                : $urandom_range(1, 4);
        repeat (k) pull_once();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls in patterns that change now and then.
    initial begin
        int unsigned mode;
        int unsigned span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    task automatic check_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_v, got_v);
            faults++;
        end
    endtask

    // Compare every result with the oldest one awaited.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none awaited, expected nothing, actual %h",
                         $time, m_data);
                faults++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", 8'(want.status), 8'(m_data.status));
                check_field("block_id", want.block_id, m_data.block_id);
                check_field("payload_byte", want.payload_byte, m_data.payload_byte);
                check_field("frame_last", 8'(want.frame_last), 8'(m_data.frame_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        dir_row_t    steps [21];
        int unsigned start;
        int unsigned last_pause;
        int unsigned kind;
        int unsigned flen;
        logic [7:0]  noise;

        // Empty store, no sync byte, short header, short frame, then a frame
        // with the largest block id and no data bytes.
        steps = '{
            '{REQ_PULL, 8'h00, 1'b1, '{ST_NONE,   8'h00, 8'h00, 1'b0}},
            '{REQ_PUSH, 8'h00, 1'b1, '{ST_PUSHED, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUSH, 8'hFF, 1'b1, '{ST_PUSHED, 8'h00, 8'h00, 1'b0}},
            '{REQ_PULL, 8'hFF, 1'b1, '{ST_NONE,   8'h00, 8'h00, 1'b0}},
            '{REQ_PUSH, 8'h24, 1'b1, '{ST_PUSHED, 8'h00, 8'h00, 1'b0}},
            '{REQ_PULL, 8'h00, 1'b1, '{ST_NONE,   8'h00, 8'h00, 1'b0}},
            '{REQ_PUSH, 8'h42, 1'b0, '0},
            '{REQ_PUSH, 8'h49, 1'b0, '0},
            '{REQ_PUSH, 8'h4E, 1'b0, '0},
            '{REQ_PUSH, 8'hFF, 1'b0, '0},
            '{REQ_PUSH, 8'h00, 1'b0, '0},
            '{REQ_PUSH, 8'h00, 1'b0, '0},
            '{REQ_PUSH, 8'h00, 1'b0, '0},
            '{REQ_PUSH, 8'hAB, 1'b0, '0},
            '{REQ_PUSH, 8'hCD, 1'b0, '0},
            '{REQ_PULL, 8'h00, 1'b1, '{ST_NONE,   8'h00, 8'h00, 1'b0}},
            '{REQ_PUSH, 8'h0D, 1'b0, '0},
            '{REQ_PUSH, 8'h0A, 1'b0, '0},
            '{REQ_PULL, 8'h00, 1'b1, '{ST_GIVEN,  8'hFF, 8'hAB, 1'b0}},
            '{REQ_PULL, 8'h00, 1'b1, '{ST_GIVEN,  8'hFF, 8'hCD, 1'b1}},
            '{REQ_PULL, 8'h00, 1'b1, '{ST_NONE,   8'h00, 8'h00, 1'b0}}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (steps[i]) begin
            issue('{req_type: steps[i].req, rx_byte: steps[i].data_in},
                  steps[i].typed, steps[i].want);
        end
        quiesce();

        // Mostly well-formed frames, with broken frames and noise mixed in.
        start = items_sent;
        last_pause = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                               : $urandom_range(0, 24);
            if (kind < 6) begin
                send_frame(flen, FLAW_NONE);
            end else if (kind == 6) begin
                send_frame(flen, FLAW_HEADER);
            end else if (kind == 7) begin
                send_frame(flen, FLAW_EPILOGUE);
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    noise = ($urandom_range(0, 7) == 0) ? SYNC_CHAR
                                                        : 8'($urandom_range(0, 255));
                    push_mixed(noise);
                end
                repeat ($urandom_range(1, 3)) pull_once();
            end
            if (items_sent - last_pause >= 400) begin
                quiesce();
                last_pause = items_sent;
            end
        end

        // One frame that fills the store to the last byte.
        quiesce();
        while (mir_drain > 0) begin
            pull_once();
        end
        flen = (mir_fill < 4000) ? BFE_BUFFER_DEPTH - FRAMING_BYTES - mir_fill : 100;
        send_frame(flen, FLAW_NONE);
        quiesce();

        // A frame longer than the store: it fills, pushes are refused and
        // pulls find nothing ready from then on.
        while (mir_drain > 0) begin
            pull_once();
        end
        issue('{req_type: REQ_PUSH, rx_byte: SYNC_CHAR}, 1'b0, '0);
        issue('{req_type: REQ_PUSH, rx_byte: CHAR_B}, 1'b0, '0);
        issue('{req_type: REQ_PUSH, rx_byte: CHAR_I}, 1'b0, '0);
        issue('{req_type: REQ_PUSH, rx_byte: CHAR_N}, 1'b0, '0);
        issue('{req_type: REQ_PUSH, rx_byte: 8'h5A}, 1'b0, '0);
        issue('{req_type: REQ_PUSH, rx_byte: 8'h00}, 1'b0, '0);
        issue('{req_type: REQ_PUSH, rx_byte: 8'hFF}, 1'b0, '0);
        issue('{req_type: REQ_PUSH, rx_byte: 8'hFF}, 1'b0, '0);
        while (mir_fill < BFE_BUFFER_DEPTH) begin
            push_mixed(8'($urandom_range(0, 255)));
        end
        repeat (4) begin
            issue('{req_type: REQ_PUSH, rx_byte: 8'($urandom_range(0, 255))}, 1'b0, '0);
            pull_once();
        end

        // Drain and let any late result show up.
        quiesce();
        repeat (64) @(posedge aclk);
        if (faults == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
